// File: design/rpg_pkg.sv
`timescale 1ns / 1ps

package rpg_pkg;

   // Field widths fixed by the item formats
   localparam int CHAN_W = 8;
   localparam int IDX_W  = 6;
   localparam int CSR_W  = 8;
   localparam int ADDR_W = 2;

   localparam int NUM_PIXELS_DEFAULT = 39;

   // Register indexes
   localparam logic [ADDR_W-1:0] CSR_HUE_SPEED   = 2'd0;
   localparam logic [ADDR_W-1:0] CSR_HUE_DENSITY = 2'd1;
   localparam logic [ADDR_W-1:0] CSR_SATURATION  = 2'd2;
   localparam logic [ADDR_W-1:0] CSR_BRIGHTNESS  = 2'd3;

   // Register reset values
   localparam logic [CSR_W-1:0] HUE_SPEED_RST   = 8'd2;
   localparam logic [CSR_W-1:0] HUE_DENSITY_RST = 8'd7;
   localparam logic [CSR_W-1:0] SATURATION_RST  = 8'd255;
   localparam logic [CSR_W-1:0] BRIGHTNESS_RST  = 8'd255;

   // Hue sectors: red-yellow, yellow-green, green-cyan, cyan-blue, blue-magenta, magenta-red
   typedef enum logic [2:0] {
      SEC_RY = 3'd0,
      SEC_YG = 3'd1,
      SEC_GC = 3'd2,
      SEC_CB = 3'd3,
      SEC_BM = 3'd4,
      SEC_MR = 3'd5
   } hue_sector_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } rpg_state_type;

   // Controller to datapath
   typedef struct packed {
      logic start;
      logic issue;
   } rpg_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic advance;
      logic last_pixel;
      logic busy;
   } rpg_sts_type;

   // High byte of an 8 by 8 product
   function automatic logic [CHAN_W-1:0] scale8(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b);
      logic [2*CHAN_W-1:0] prod;
      prod = (2*CHAN_W)'(a) * (2*CHAN_W)'(b);
      return prod[2*CHAN_W-1:CHAN_W];
   endfunction

   // Sector of a hue, by comparing against the sector boundaries
   function automatic hue_sector_type hue_sector(input logic [CHAN_W-1:0] hue);
      hue_sector_type sec;
      if (hue < 8'd43) begin
         sec = SEC_RY;
      end else if (hue < 8'd86) begin
         sec = SEC_YG;
      end else if (hue < 8'd129) begin
         sec = SEC_GC;
      end else if (hue < 8'd172) begin
         sec = SEC_CB;
      end else if (hue < 8'd215) begin
         sec = SEC_BM;
      end else begin
         sec = SEC_MR;
      end
      return sec;
   endfunction

   // First hue of a sector
   function automatic logic [CHAN_W-1:0] sector_base(input hue_sector_type sec);
      logic [CHAN_W-1:0] base;
      case (sec)
         SEC_RY:  base = 8'd0;
         SEC_YG:  base = 8'd43;
         SEC_GC:  base = 8'd86;
         SEC_CB:  base = 8'd129;
         SEC_BM:  base = 8'd172;
         default: base = 8'd215;
      endcase
      return base;
   endfunction

endpackage

// File: design/rpg_ctrl.sv
`timescale 1ns / 1ps

module rpg_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   output rpg_pkg::rpg_cmd_type cmd,
   input  rpg_pkg::rpg_sts_type sts
);
   import rpg_pkg::*;

   rpg_state_type state_ff;
   rpg_state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (sts.advance && sts.last_pixel) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!sts.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_tready = 1'b0;
      cmd.start  = 1'b0;
      cmd.issue  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         ST_ISSUE: begin
            cmd.issue = sts.advance;
         end
         ST_DRAIN: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/rpg_datapath.sv
`timescale 1ns / 1ps

module rpg_datapath #(
   parameter int NUM_PIXELS = rpg_pkg::NUM_PIXELS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [rpg_pkg::ADDR_W-1:0]   csr_addr,
   input  logic [rpg_pkg::CSR_W-1:0]    csr_wdata,
   input  logic                         restart,
   input  rpg_pkg::rpg_cmd_type         cmd,
   output rpg_pkg::rpg_sts_type         sts,
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [rpg_pkg::IDX_W-1:0]    pixel_pos,
   output logic [rpg_pkg::CHAN_W-1:0]   red,
   output logic [rpg_pkg::CHAN_W-1:0]   green,
   output logic [rpg_pkg::CHAN_W-1:0]   blue,
   output logic                         frame_end
);
   import rpg_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_PIXELS - 1);

   // Configuration registers
   logic [CSR_W-1:0] speed_ff, density_ff, sat_ff, val_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff   <= HUE_SPEED_RST;
         density_ff <= HUE_DENSITY_RST;
         sat_ff     <= SATURATION_RST;
         val_ff     <= BRIGHTNESS_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_HUE_SPEED:   speed_ff   <= csr_wdata;
            CSR_HUE_DENSITY: density_ff <= csr_wdata;
            CSR_SATURATION:  sat_ff     <= csr_wdata;
            CSR_BRIGHTNESS:  val_ff     <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Pipeline advances whenever the output register is free or being drained
   logic advance;
   assign advance = !rsp_tvalid || rsp_tready;

   // Frame offset, pixel hue and pixel counter
   logic [CHAN_W-1:0] offset_ff, offset_in;
   logic [CHAN_W-1:0] hue_ff, hue_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [CHAN_W-1:0] start_hue;

   assign start_hue = restart ? '0 : offset_ff;

   always_comb begin
      offset_in = offset_ff;
      hue_in    = hue_ff;
      idx_in    = idx_ff;
      if (cmd.start) begin
         // Next frame starts one speed step beyond this one
         offset_in = start_hue + speed_ff;
         hue_in    = start_hue;
         idx_in    = '0;
      end else if (cmd.issue) begin
         hue_in = hue_ff + density_ff;
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
      end else begin
         offset_ff <= offset_in;
      end
   end

   always_ff @(posedge clock) begin
      hue_ff <= hue_in;
      idx_ff <= idx_in;
   end

   // Stage 1: sector and scaled remainder
   logic            s1_valid_ff, s1_valid_in;
   hue_sector_type  s1_sec_ff, s1_sec_in;
   logic [CHAN_W-1:0] s1_rem_ff, s1_rem_in;
   logic [IDX_W-1:0]  s1_idx_ff;
   logic              s1_last_ff;
   logic [CHAN_W-1:0] hue_off;

   assign s1_sec_in   = hue_sector(hue_ff);
   assign hue_off     = hue_ff - sector_base(s1_sec_in);
   assign s1_rem_in   = hue_off * 8'd6;
   assign s1_valid_in = advance ? cmd.issue : s1_valid_ff;

   // Stage 2: saturation products and p
   logic              s2_valid_ff;
   hue_sector_type    s2_sec_ff;
   logic [CHAN_W-1:0] s2_m1_ff, s2_m2_ff, s2_p_ff;
   logic [IDX_W-1:0]  s2_idx_ff;
   logic              s2_last_ff;
   logic [CHAN_W-1:0] s2_m1_in, s2_m2_in, s2_p_in;

   assign s2_m1_in = scale8(sat_ff, s1_rem_ff);
   assign s2_m2_in = scale8(sat_ff, 8'd255 - s1_rem_ff);
   assign s2_p_in  = scale8(val_ff, 8'd255 - sat_ff);

   // Stage 3: q and t
   logic              s3_valid_ff;
   hue_sector_type    s3_sec_ff;
   logic [CHAN_W-1:0] s3_q_ff, s3_t_ff, s3_p_ff;
   logic [IDX_W-1:0]  s3_idx_ff;
   logic              s3_last_ff;
   logic [CHAN_W-1:0] s3_q_in, s3_t_in;

   assign s3_q_in = scale8(val_ff, 8'd255 - s2_m1_ff);
   assign s3_t_in = scale8(val_ff, 8'd255 - s2_m2_ff);

   // Output stage: route by sector, grey at zero saturation
   logic              out_valid_ff, out_valid_in;
   logic [CHAN_W-1:0] red_ff, green_ff, blue_ff;
   logic [CHAN_W-1:0] red_in, green_in, blue_in;
   logic [IDX_W-1:0]  out_idx_ff;
   logic              out_last_ff;

   always_comb begin
      red_in   = val_ff;
      green_in = val_ff;
      blue_in  = val_ff;
      if (sat_ff != '0) begin
         case (s3_sec_ff)
            SEC_RY:  begin red_in = val_ff;  green_in = s3_t_ff; blue_in = s3_p_ff; end
            SEC_YG:  begin red_in = s3_q_ff; green_in = val_ff;  blue_in = s3_p_ff; end
            SEC_GC:  begin red_in = s3_p_ff; green_in = val_ff;  blue_in = s3_t_ff; end
            SEC_CB:  begin red_in = s3_p_ff; green_in = s3_q_ff; blue_in = val_ff;  end
            SEC_BM:  begin red_in = s3_t_ff; green_in = s3_p_ff; blue_in = val_ff;  end
            default: begin red_in = val_ff;  green_in = s3_p_ff; blue_in = s3_q_ff; end
         endcase
      end
   end

   assign out_valid_in = advance ? s3_valid_ff : out_valid_ff;

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // Payload: shift all stages together, hold on stall
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_sec_ff   <= s1_sec_in;
         s1_rem_ff   <= s1_rem_in;
         s1_idx_ff   <= idx_ff;
         s1_last_ff  <= (idx_ff == LAST_IDX);
         s2_sec_ff   <= s1_sec_ff;
         s2_m1_ff    <= s2_m1_in;
         s2_m2_ff    <= s2_m2_in;
         s2_p_ff     <= s2_p_in;
         s2_idx_ff   <= s1_idx_ff;
         s2_last_ff  <= s1_last_ff;
         s3_sec_ff   <= s2_sec_ff;
         s3_q_ff     <= s3_q_in;
         s3_t_ff     <= s3_t_in;
         s3_p_ff     <= s2_p_ff;
         s3_idx_ff   <= s2_idx_ff;
         s3_last_ff  <= s2_last_ff;
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         out_idx_ff  <= s3_idx_ff;
         out_last_ff <= s3_last_ff;
      end
   end

   assign sts.advance    = advance;
   assign sts.last_pixel = (idx_ff == LAST_IDX);
   assign sts.busy       = s1_valid_ff || s2_valid_ff || s3_valid_ff || out_valid_ff;

   assign rsp_tvalid = out_valid_ff;
   assign pixel_pos  = out_idx_ff;
   assign red        = red_ff;
   assign green      = green_ff;
   assign blue       = blue_ff;
   assign frame_end  = out_last_ff;

endmodule

// File: design/rainbow_pattern_generator.sv
`timescale 1ns / 1ps

// Rainbow pattern generator. Each item taken on the req channel is one frame
// tick (req_tdata bit 0 = restart, which zeroes the hue offset first). The
// block then emits NUM_PIXELS pixel items on the rsp channel, one per cycle
// while rsp_tready stays high, in strip order, with rsp_tlast on the last
// one. Pixel hue is offset + index * density (mod 256), converted to RGB with
// 8-bit HSV arithmetic in a four-stage pipeline (sector, saturation products,
// value products, channel routing). Once a frame is accepted, req_tready stays
// low until its last pixel has been taken from the output register, so a new
// frame is not taken before the previous one is fully delivered. The issue
// counter steps one pixel per cycle while the pipeline advances; rsp_tready
// stalls hold it and lengthen the frame. req_tready is high only when no pixel
// is in flight. Registers must be written through csr_we / csr_addr / csr_wdata
// only while the block is idle, which the block itself does not enforce:
// 0 hue speed, 1 hue density, 2 saturation, 3 brightness.

module rainbow_pattern_generator #(
   parameter int NUM_PIXELS = rpg_pkg::NUM_PIXELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [0] restart, [7:1] zero
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [31:0]                rsp_tdata,   // [5:0] pixel position, [13:6] red,
                                                   // [21:14] green, [29:22] blue, [31:30] zero
   output logic                       rsp_tlast,
   input  logic                       csr_we,
   input  logic [rpg_pkg::ADDR_W-1:0] csr_addr,
   input  logic [rpg_pkg::CSR_W-1:0]  csr_wdata
);
   import rpg_pkg::*;

   rpg_cmd_type       cmd;
   rpg_sts_type       sts;
   logic [IDX_W-1:0]  pixel_pos;
   logic [CHAN_W-1:0] red, green, blue;

   rpg_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   rpg_datapath #(
      .NUM_PIXELS (NUM_PIXELS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .restart     (req_tdata[0]),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .pixel_pos   (pixel_pos),
      .red         (red),
      .green       (green),
      .blue        (blue),
      .frame_end   (rsp_tlast)
   );

   assign rsp_tdata = {2'b00, blue, green, red, pixel_pos};

   // A new frame is taken only with nothing left to deliver
   assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("frame accepted while pixels pending");

   // The flagged pixel is the last one of the strip
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (rsp_tdata[5:0] == IDX_W'(NUM_PIXELS - 1)))
      else $error("frame end on wrong pixel");

   // Accepting a frame closes the input
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input still open after frame accept");

   // More pixels follow a non-final pixel, so the input stays closed
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> !req_tready)
      else $error("input opened mid frame");

endmodule
